@@ rtl/assert_macros.svh @@
// Assertion helper macros shared by the RTL files.
// No dependencies. Define ASSERT_OFF to compile the checks away.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
// expression holds at every clock edge out of reset
`define ASSERT_ALWAYS(lbl, clk, rst_n, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);
// antecedent implies consequent in the same cycle
`define ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
// antecedent implies consequent in the next cycle
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define ASSERT_ALWAYS(lbl, clk, rst_n, expr, msg)
`define ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif

`endif

@@ rtl/pres_pkg.sv @@
// Package for the path resolver: sizes, character and code constants, types.
// No dependencies; used by path_resolver and path_resolver_tb.
`default_nettype none

package pres_pkg;

    localparam int MAX_LEN     = 255;
    localparam int STORE_DEPTH = MAX_LEN + 3;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int LEN_W       = $clog2(MAX_LEN + 2);
    localparam int CMP_W       = (LEN_W > 8) ? LEN_W : 8;

    typedef logic [LEN_W-1:0]  len_t;
    typedef logic [ADDR_W-1:0] addr_t;

    localparam len_t MAX_LEN_L = len_t'(MAX_LEN);

    // characters
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_DOT   = 8'h2E;

    // item kinds
    localparam logic [1:0] KIND_CWD  = 2'd0;
    localparam logic [1:0] KIND_PATH = 2'd1;
    localparam logic [1:0] KIND_READ = 2'd2;

    // result status codes
    localparam logic [1:0] STAT_COLLECT = 2'd0;
    localparam logic [1:0] STAT_OK      = 2'd1;
    localparam logic [1:0] STAT_INVALID = 2'd2;

    // request phase
    typedef enum logic [2:0] {
        PH_IDLE,
        PH_CWD,
        PH_CWD_DONE,
        PH_PATH,
        PH_DONE,
        PH_DRAIN,
        PH_FAIL
    } phase_t;

    // sequencer state
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_EMIT,
        ST_WALK,
        ST_RESP
    } state_t;

endpackage

`default_nettype wire

@@ rtl/pres_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`default_nettype none

module pres_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 258
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

@@ rtl/path_resolver.sv @@
// Path resolver: an item that stores nothing passes accept, execute and respond.
// Each path name character is appended to the store in the append state, and it may
// first release a held slash and two held dots, each appended before it.
// A ".." component walks back over the stored characters, one stored character per
// cycle through the path store read port. Result register frees the input side early.
// Reset (rst_n, async, low): idle, length 1 holding the root slash; store is not cleared.
`default_nettype none
`include "assert_macros.svh"

module path_resolver (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       req_valid,
    output logic            req_ready,
    input  wire logic [1:0] kind,
    input  wire logic [7:0] ch,
    input  wire logic [7:0] read_index,
    output logic            rsp_valid,
    input  wire logic       rsp_ready,
    output logic      [1:0] status,
    output logic      [7:0] result_length,
    output logic      [7:0] out_char
);

    import pres_pkg::*;

    // control state
    state_t     state_reg, state_next;
    phase_t     phase_reg, phase_next;
    len_t       stored_reg, stored_next;
    len_t       count_reg, count_next;
    logic [1:0] comp_reg, comp_next;      // component length, saturates at 3
    logic       dots_reg, dots_next;
    logic       dir_valid_reg, dir_valid_next;
    logic [7:0] root_reg, root_next;      // entry 0 of the store
    logic       rsp_valid_reg, rsp_valid_next;

    // item and work payload
    logic [1:0] kind_reg, kind_next;
    logic [7:0] ch_reg, ch_next;
    logic [7:0] idx_reg, idx_next;
    logic       emit_slash_reg, emit_slash_next;
    logic [1:0] emit_dots_reg, emit_dots_next;
    len_t       walk_reg, walk_next;
    logic       walk_name_reg, walk_name_next;
    logic       rd_ok_reg, rd_ok_next;
    logic [1:0] status_reg, status_next;
    logic [7:0] length_reg, length_next;
    logic [7:0] char_reg, char_next;

    // store port
    logic       mem_we;
    addr_t      mem_waddr;
    logic [7:0] mem_wdata;
    addr_t      mem_raddr;
    logic [7:0] mem_rdata;

    // decode helpers
    logic       cwd_start;
    len_t       cwd_cnt;
    logic [7:0] cwd_root;
    logic       cwd_ok;
    logic       path_start;
    logic       dir_eff;
    logic       pc_run;
    len_t       pc_cnt;
    logic [1:0] pc_comp;
    logic       pc_dots;
    len_t       pc_stored;
    logic       nc_dots;
    logic       dotdot;
    logic       failed;
    logic       read_hit;

    pres_ram #(
        .WIDTH (8),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // effective state for the item in execution
    always_comb
    begin
        cwd_start  = (phase_reg == PH_IDLE) || (phase_reg == PH_CWD_DONE) ||
                     (phase_reg == PH_DONE) || (phase_reg == PH_FAIL);
        cwd_cnt    = cwd_start ? '0 : count_reg;
        cwd_root   = cwd_start ? CH_SLASH : root_reg;
        cwd_ok     = (cwd_cnt != '0) && (cwd_cnt <= MAX_LEN_L) && (cwd_root == CH_SLASH);

        path_start = cwd_start;
        dir_eff    = (phase_reg == PH_CWD_DONE) && dir_valid_reg;
        pc_run     = (phase_reg == PH_PATH) ||
                     (path_start && (ch_reg != CH_NUL) && ((ch_reg == CH_SLASH) || dir_eff));
        pc_cnt     = path_start ? '0 : count_reg;
        pc_comp    = path_start ? 2'd0 : comp_reg;
        pc_dots    = path_start ? 1'b0 : dots_reg;
        pc_stored  = (path_start && (ch_reg == CH_SLASH)) ? len_t'(1) : stored_reg;
        nc_dots    = (pc_comp == 2'd0) || pc_dots;
        dotdot     = pc_dots && (pc_comp == 2'd2);

        failed     = (phase_reg == PH_DRAIN) || (phase_reg == PH_FAIL);
        read_hit   = (kind_reg == KIND_READ) && !failed &&
                     (CMP_W'(idx_reg) < CMP_W'(stored_reg));
    end

    // store read address: walk pointer while walking back, else read index
    always_comb
    begin
        if (state_reg == ST_WALK)
        begin
            mem_raddr = rd_ok_reg ? addr_t'(walk_reg - len_t'(2)) : addr_t'(walk_reg - len_t'(1));
        end
        else
        begin
            mem_raddr = addr_t'(idx_reg);
        end
    end

    // sequencer: next state and datapath
    always_comb
    begin
        state_next      = state_reg;
        phase_next      = phase_reg;
        stored_next     = stored_reg;
        count_next      = count_reg;
        comp_next       = comp_reg;
        dots_next       = dots_reg;
        dir_valid_next  = dir_valid_reg;
        root_next       = root_reg;
        rsp_valid_next  = rsp_valid_reg && !rsp_ready;
        kind_next       = kind_reg;
        ch_next         = ch_reg;
        idx_next        = idx_reg;
        emit_slash_next = emit_slash_reg;
        emit_dots_next  = emit_dots_reg;
        walk_next       = walk_reg;
        walk_name_next  = walk_name_reg;
        rd_ok_next      = rd_ok_reg;
        status_next     = status_reg;
        length_next     = length_reg;
        char_next       = char_reg;
        mem_we          = 1'b0;
        mem_waddr       = addr_t'(stored_reg);
        mem_wdata       = ch_reg;
        req_ready       = (state_reg == ST_IDLE);

        case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    kind_next  = kind;
                    ch_next    = ch;
                    idx_next   = read_index;
                    state_next = ST_EXEC;
                end
            end

            ST_EXEC:
            begin
                state_next = ST_RESP;
                case (kind_reg)
                    KIND_CWD:
                    begin
                        if (cwd_start || (phase_reg == PH_CWD))
                        begin
                            if (cwd_start)
                            begin
                                phase_next     = PH_CWD;
                                dir_valid_next = 1'b0;
                                comp_next      = 2'd0;
                                dots_next      = 1'b0;
                                root_next      = CH_SLASH;
                                stored_next    = '0;
                                count_next     = '0;
                            end
                            if (ch_reg == CH_NUL)
                            begin
                                dir_valid_next = cwd_ok;
                                if (!cwd_ok)
                                begin
                                    root_next   = CH_SLASH;
                                    stored_next = len_t'(1);
                                end
                                phase_next = PH_CWD_DONE;
                            end
                            else
                            begin
                                if (cwd_cnt < MAX_LEN_L)
                                begin
                                    if (cwd_cnt == '0)
                                    begin
                                        root_next = ch_reg;
                                    end
                                    else
                                    begin
                                        mem_we    = 1'b1;
                                        mem_waddr = addr_t'(cwd_cnt);
                                    end
                                    stored_next = len_t'(cwd_cnt + len_t'(1));
                                end
                                if (cwd_cnt <= MAX_LEN_L)
                                begin
                                    count_next = len_t'(cwd_cnt + len_t'(1));
                                end
                            end
                        end
                    end

                    KIND_PATH:
                    begin
                        // new request: clear component state; root if absolute, empty or no directory
                        if (path_start)
                        begin
                            if (phase_reg != PH_CWD_DONE)
                            begin
                                dir_valid_next = 1'b0;
                            end
                            count_next = '0;
                            comp_next  = 2'd0;
                            dots_next  = 1'b0;
                            if ((ch_reg == CH_NUL) || (ch_reg == CH_SLASH) || !dir_eff)
                            begin
                                root_next   = CH_SLASH;
                                stored_next = len_t'(1);
                            end
                            if (ch_reg == CH_NUL)
                            begin
                                phase_next = PH_FAIL;
                            end
                            else if (!pc_run)
                            begin
                                phase_next = PH_DRAIN;
                            end
                        end
                        else if (phase_reg == PH_DRAIN)
                        begin
                            if (ch_reg == CH_NUL)
                            begin
                                phase_next = PH_FAIL;
                            end
                        end

                        if (pc_run)
                        begin
                            phase_next = PH_PATH;
                            if (ch_reg == CH_NUL)
                            begin
                                phase_next = PH_DONE;
                                comp_next  = 2'd0;
                                dots_next  = 1'b0;
                                if (dotdot)
                                begin
                                    state_next = ST_WALK;
                                end
                            end
                            else
                            begin
                                count_next = len_t'(pc_cnt + len_t'(1));
                                if (pc_cnt >= MAX_LEN_L)
                                begin
                                    phase_next = PH_DRAIN;
                                end
                                else if (ch_reg == CH_SLASH)
                                begin
                                    comp_next = 2'd0;
                                    dots_next = 1'b0;
                                    if (dotdot)
                                    begin
                                        state_next = ST_WALK;
                                    end
                                end
                                else if (nc_dots && (ch_reg == CH_DOT) && (pc_comp <= 2'd1))
                                begin
                                    // hold dots back until the component is a name
                                    comp_next = pc_comp + 2'd1;
                                    dots_next = 1'b1;
                                end
                                else
                                begin
                                    emit_slash_next = nc_dots && (pc_stored != len_t'(1));
                                    emit_dots_next  = nc_dots ? pc_comp : 2'd0;
                                    dots_next       = 1'b0;
                                    comp_next       = (pc_comp == 2'd3) ? 2'd3 : pc_comp + 2'd1;
                                    state_next      = ST_EMIT;
                                end
                            end
                        end
                    end

                    default:
                    begin
                        // read back uses the registered store data in ST_RESP
                    end
                endcase

                if (state_next == ST_WALK)
                begin
                    walk_next      = stored_reg;
                    walk_name_next = 1'b0;
                    rd_ok_next     = 1'b0;
                end
            end

            // append held slash, held dots, then the character; drain once the store is full
            ST_EMIT:
            begin
                if (stored_reg >= MAX_LEN_L)
                begin
                    phase_next = PH_DRAIN;
                    state_next = ST_RESP;
                end
                else
                begin
                    mem_we      = 1'b1;
                    mem_waddr   = addr_t'(stored_reg);
                    stored_next = len_t'(stored_reg + len_t'(1));
                    if (emit_slash_reg)
                    begin
                        mem_wdata       = CH_SLASH;
                        emit_slash_next = 1'b0;
                    end
                    else if (emit_dots_reg != 2'd0)
                    begin
                        mem_wdata      = CH_DOT;
                        emit_dots_next = emit_dots_reg - 2'd1;
                    end
                    else
                    begin
                        mem_wdata  = ch_reg;
                        state_next = ST_RESP;
                    end
                end
            end

            // parent: strip trailing slashes, then the name, then its slash
            ST_WALK:
            begin
                if (walk_reg <= len_t'(1))
                begin
                    stored_next = walk_reg;
                    state_next  = ST_RESP;
                end
                else if (!rd_ok_reg)
                begin
                    rd_ok_next = 1'b1;
                end
                else
                begin
                    walk_next = len_t'(walk_reg - len_t'(1));
                    if (!walk_name_reg)
                    begin
                        if (mem_rdata != CH_SLASH)
                        begin
                            walk_name_next = 1'b1;
                        end
                    end
                    else if (mem_rdata == CH_SLASH)
                    begin
                        stored_next = len_t'(walk_reg - len_t'(1));
                        state_next  = ST_RESP;
                    end
                end
            end

            // load the result register once it is free
            ST_RESP:
            begin
                if (!rsp_valid_reg || rsp_ready)
                begin
                    rsp_valid_next = 1'b1;
                    status_next    = failed ? STAT_INVALID :
                                     ((phase_reg == PH_DONE) ? STAT_OK : STAT_COLLECT);
                    length_next    = failed ? 8'd0 : 8'(stored_reg);
                    if (read_hit)
                    begin
                        char_next = (idx_reg == 8'd0) ? root_reg : mem_rdata;
                    end
                    else
                    begin
                        char_next = 8'd0;
                    end
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            phase_reg     <= PH_IDLE;
            stored_reg    <= len_t'(1);
            count_reg     <= '0;
            comp_reg      <= 2'd0;
            dots_reg      <= 1'b0;
            dir_valid_reg <= 1'b0;
            root_reg      <= CH_SLASH;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            stored_reg    <= stored_next;
            count_reg     <= count_next;
            comp_reg      <= comp_next;
            dots_reg      <= dots_next;
            dir_valid_reg <= dir_valid_next;
            root_reg      <= root_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        kind_reg       <= kind_next;
        ch_reg         <= ch_next;
        idx_reg        <= idx_next;
        emit_slash_reg <= emit_slash_next;
        emit_dots_reg  <= emit_dots_next;
        walk_reg       <= walk_next;
        walk_name_reg  <= walk_name_next;
        rd_ok_reg      <= rd_ok_next;
        status_reg     <= status_next;
        length_reg     <= length_next;
        char_reg       <= char_next;
    end

    assign rsp_valid     = rsp_valid_reg;
    assign status        = status_reg;
    assign result_length = length_reg;
    assign out_char      = char_reg;

    // checks
    `ASSERT_ALWAYS(a_len_max, clk, rst_n, stored_reg <= MAX_LEN_L, "stored length over limit")
    `ASSERT_NEXT(a_walk_down, clk, rst_n, (state_reg == ST_WALK) && (state_next == ST_WALK), walk_reg <= $past(walk_reg), "walk pointer moved up")
    `ASSERT_IMP(a_we_state, clk, rst_n, mem_we, (state_reg == ST_EXEC) || (state_reg == ST_EMIT), "store write outside execute or append")
    `ASSERT_IMP(a_fail_len, clk, rst_n, rsp_valid && (status == STAT_INVALID), result_length == 8'd0, "invalid result with nonzero length")

endmodule

`default_nettype wire

@@ dv/path_resolver_tb.sv @@
// Self-checking testbench for path_resolver: directed and random character items.
// Predicts every response with an in-bench path canonicalizer; depends on pres_pkg.
module path_resolver_tb;
    import pres_pkg::*;

    localparam logic [1:0] KIND_NOP     = 2'd3;
    localparam int         RANDOM_ITEMS = 1500;
    localparam int         CYCLE_LIMIT  = 2000000;
    localparam int         DRAIN_CYCLES = 32;

    typedef struct packed {
        logic [1:0] op;
        logic [7:0] chr;
        logic [7:0] idx;
    } char_item_t;

    typedef struct packed {
        logic [1:0] status;
        logic [7:0] len;
        logic [7:0] ochar;
    } resolve_rsp_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       req_valid = 1'b0;
    logic       req_ready;
    logic [1:0] kind = 2'd0;
    logic [7:0] ch = 8'd0;
    logic [7:0] read_index = 8'd0;
    logic       rsp_valid;
    logic       rsp_ready = 1'b0;
    logic [1:0] status;
    logic [7:0] result_length;
    logic [7:0] out_char;

    char_item_t   char_q[$];
    resolve_rsp_t resolved_q[$];
    char_item_t   drive_item;
    resolve_rsp_t want_rsp;
    int           send_wait;
    int           recv_wait;
    bit           send_quiet;
    bit           recv_quiet;
    int           accepted_count;
    int           cycle_count;
    int           mismatches;

    // predictor state: resolved path image and request tracking
    logic [7:0] path_img [0:STORE_DEPTH-1];
    logic [8:0] img_len;
    phase_t     cur_phase;
    logic [8:0] comp_len;
    logic       comp_dots;
    logic [8:0] char_count;
    logic       dir_ok;

    path_resolver dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .req_valid     (req_valid),
        .req_ready     (req_ready),
        .kind          (kind),
        .ch            (ch),
        .read_index    (read_index),
        .rsp_valid     (rsp_valid),
        .rsp_ready     (rsp_ready),
        .status        (status),
        .result_length (result_length),
        .out_char      (out_char)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // ---------------- predictor ----------------

    function automatic void load_root();
        path_img[0] = CH_SLASH;
        img_len = 9'd1;
    endfunction

    function automatic bit append_char(logic [7:0] c);
        if (img_len >= MAX_LEN)
            return 1'b0;
        path_img[img_len] = c;
        img_len++;
        return 1'b1;
    endfunction

    // drop trailing slashes, the last name and the slash before it
    function automatic void climb_parent();
        int n;
        n = img_len;
        while (n > 1 && path_img[n-1] == CH_SLASH)
            n--;
        while (n > 1 && path_img[n-1] != CH_SLASH)
            n--;
        if (n > 1 && path_img[n-1] == CH_SLASH)
            n--;
        img_len = 9'(n);
    endfunction

    function automatic void close_component();
        if (comp_dots && comp_len == 2)
            climb_parent();
        comp_len = 9'd0;
        comp_dots = 1'b0;
    endfunction

    // leading dots are held back until the name is known not to be . or ..
    function automatic bit add_name_char(logic [7:0] c);
        logic [8:0] nxt;
        nxt = comp_len + 9'd1;
        if (comp_len == 0)
            comp_dots = 1'b1;
        if (comp_dots && c == CH_DOT && nxt <= 2)
        begin
            comp_len = nxt;
            return 1'b1;
        end
        if (comp_dots)
        begin
            if (img_len != 1 && !append_char(CH_SLASH))
                return 1'b0;
            for (int i = 0; i < comp_len; i++)
                if (!append_char(CH_DOT))
                    return 1'b0;
            comp_dots = 1'b0;
        end
        if (!append_char(c))
            return 1'b0;
        comp_len = nxt;
        return 1'b1;
    endfunction

    function automatic void take_path_char(logic [7:0] c);
        if (c == CH_NUL)
        begin
            close_component();
            cur_phase = PH_DONE;
            return;
        end
        char_count++;
        if (char_count > MAX_LEN)
        begin
            cur_phase = PH_DRAIN;
            return;
        end
        if (c == CH_SLASH)
            close_component();
        else if (!add_name_char(c))
            cur_phase = PH_DRAIN;
    endfunction

    function automatic void open_path(logic [7:0] c);
        if (cur_phase == PH_DONE || cur_phase == PH_FAIL || cur_phase == PH_IDLE)
            dir_ok = 1'b0;
        char_count = 9'd0;
        comp_len = 9'd0;
        comp_dots = 1'b0;
        if (c == CH_NUL)
        begin
            load_root();
            cur_phase = PH_FAIL;
            return;
        end
        if (c == CH_SLASH)
            load_root();
        else if (!dir_ok)
        begin
            load_root();
            cur_phase = PH_DRAIN;
            return;
        end
        cur_phase = PH_PATH;
        take_path_char(c);
    endfunction

    // directory characters are copied verbatim
    function automatic void take_dir_char(logic [7:0] c);
        if (c == CH_NUL)
        begin
            dir_ok = char_count >= 1 && char_count <= MAX_LEN && path_img[0] == CH_SLASH;
            if (!dir_ok)
                load_root();
            cur_phase = PH_CWD_DONE;
            return;
        end
        if (char_count < MAX_LEN)
        begin
            path_img[char_count] = c;
            img_len = char_count + 9'd1;
        end
        if (char_count <= MAX_LEN)
            char_count++;
    endfunction

    function automatic resolve_rsp_t resolve_item(logic [1:0] k, logic [7:0] c,
                                                  logic [7:0] idx);
        resolve_rsp_t r;
        logic         failed;
        if (k == KIND_CWD)
        begin
            if (cur_phase == PH_IDLE || cur_phase == PH_CWD_DONE ||
                cur_phase == PH_DONE || cur_phase == PH_FAIL)
            begin
                char_count = 9'd0;
                dir_ok = 1'b0;
                comp_len = 9'd0;
                comp_dots = 1'b0;
                cur_phase = PH_CWD;
                load_root();
                img_len = 9'd0;
            end
            if (cur_phase == PH_CWD)
                take_dir_char(c);
        end
        else if (k == KIND_PATH)
        begin
            if (cur_phase == PH_PATH)
                take_path_char(c);
            else if (cur_phase == PH_DRAIN)
            begin
                if (c == CH_NUL)
                    cur_phase = PH_FAIL;
            end
            else if (cur_phase != PH_CWD)
                open_path(c);
        end
        failed = (cur_phase == PH_DRAIN || cur_phase == PH_FAIL);
        r.status = failed ? STAT_INVALID : (cur_phase == PH_DONE ? STAT_OK : STAT_COLLECT);
        r.len = failed ? 8'd0 : img_len[7:0];
        r.ochar = (k == KIND_READ && !failed && idx < img_len) ? path_img[idx] : 8'd0;
        return r;
    endfunction

    // ---------------- stimulus builders ----------------

    function automatic logic [7:0] any_index();
        return 8'($urandom_range(0, 254));
    endfunction

    // name character: mostly letters, sometimes any byte but NUL, slash, dot
    function automatic logic [7:0] name_byte();
        logic [7:0] b;
        if ($urandom_range(0, 3) != 0)
            return 8'h61 + 8'($urandom_range(0, 25));
        do
            b = 8'($urandom_range(1, 255));
        while (b == CH_SLASH || b == CH_DOT);
        return b;
    endfunction

    function automatic int draw_gap(inout bit quiet);
        if ($urandom_range(0, 24) == 0)
            quiet = !quiet;
        return quiet ? 0 : $urandom_range(0, 10);
    endfunction

    task automatic push_item(logic [1:0] k, logic [7:0] c, logic [7:0] idx);
        char_q.push_back('{op: k, chr: c, idx: idx});
    endtask

    task automatic push_text(logic [1:0] k, string s);
        for (int i = 0; i < s.len(); i++)
            push_item(k, s[i], any_index());
    endtask

    task automatic push_reads(int count);
        repeat (count)
            push_item(KIND_READ, 8'($urandom_range(0, 255)),
                      ($urandom_range(0, 3) == 0) ? any_index() : 8'($urandom_range(0, 15)));
    endtask

    // components: names, ".", "..", "...", dotted names, joined by slash runs
    task automatic push_components(logic [1:0] k, int count, int name_max);
        int sel;
        for (int j = 0; j < count; j++)
        begin
            sel = $urandom_range(0, 9);
            case (sel)
                0: push_text(k, ".");
                1, 2: push_text(k, "..");
                3: push_text(k, "...");
                4:
                begin
                    repeat ($urandom_range(1, 2))
                        push_item(k, CH_DOT, any_index());
                    push_item(k, name_byte(), any_index());
                end
                default:
                    repeat ($urandom_range(1, name_max))
                        push_item(k, name_byte(), any_index());
            endcase
            if (j < count - 1 || $urandom_range(0, 3) == 0)
                repeat (($urandom_range(0, 4) == 0) ? $urandom_range(1, 3) : 1)
                    push_item(k, CH_SLASH, any_index());
        end
    endtask

    // optional directory, then an absolute or relative path, then read-back
    task automatic push_request(int parts, int name_max);
        int sel;
        sel = $urandom_range(0, 9);
        if (sel < 6)
        begin
            push_item(KIND_CWD, CH_SLASH, any_index());
            push_components(KIND_CWD, $urandom_range(0, parts), name_max);
            push_item(KIND_CWD, CH_NUL, any_index());
        end
        else if (sel == 6)
        begin
            push_components(KIND_CWD, $urandom_range(1, 3), 4);
            push_item(KIND_CWD, CH_NUL, any_index());
        end
        else if (sel == 7)
            push_item(KIND_CWD, CH_NUL, any_index());
        if ($urandom_range(0, 1) == 1)
            push_item(KIND_PATH, CH_SLASH, any_index());
        push_components(KIND_PATH, $urandom_range(0, parts), name_max);
        push_item(KIND_PATH, CH_NUL, any_index());
        push_reads($urandom_range(0, 3));
    endtask

    task automatic push_noise();
        repeat ($urandom_range(5, 15))
            push_item(2'($urandom_range(0, 3)),
                      ($urandom_range(0, 3) == 0) ? CH_NUL : 8'($urandom_range(0, 255)),
                      any_index());
    endtask

    // path items inside an open directory, directory items inside a path
    task automatic push_misplaced();
        push_item(KIND_CWD, CH_SLASH, any_index());
        push_components(KIND_CWD, $urandom_range(1, 3), 4);
        push_item(KIND_PATH, name_byte(), any_index());
        if ($urandom_range(0, 1) == 1)
            push_item(KIND_CWD, CH_NUL, any_index());
        push_item(KIND_PATH, CH_DOT, any_index());
        push_components(KIND_PATH, $urandom_range(1, 3), 4);
        push_item(KIND_CWD, name_byte(), any_index());
        if ($urandom_range(0, 1) == 1)
            push_item(KIND_PATH, CH_NUL, any_index());
        push_reads(1);
    endtask

    // absolute path around the input length limit
    task automatic push_long_path();
        push_item(KIND_PATH, CH_SLASH, any_index());
        repeat ($urandom_range(MAX_LEN - 10, MAX_LEN + 5))
            push_item(KIND_PATH, ($urandom_range(0, 7) == 0) ? CH_SLASH : name_byte(),
                      any_index());
        push_item(KIND_PATH, CH_NUL, any_index());
        push_reads(2);
    endtask

    // directory near the length limit, then a relative path that may overflow
    task automatic push_deep_directory();
        push_item(KIND_CWD, CH_SLASH, any_index());
        repeat ($urandom_range(MAX_LEN - 9, MAX_LEN))
            push_item(KIND_CWD, ($urandom_range(0, 9) == 0) ? CH_SLASH : name_byte(),
                      any_index());
        push_item(KIND_CWD, CH_NUL, any_index());
        push_components(KIND_PATH, $urandom_range(1, 4), 6);
        push_item(KIND_PATH, CH_NUL, any_index());
        push_item(KIND_READ, CH_NUL, 8'($urandom_range(245, 254)));
    endtask

    // ---------------- driver ----------------

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid <= 1'b0;
            send_wait = 0;
        end
        else
        begin
            if (req_valid && req_ready)
            begin
                resolved_q.push_back(resolve_item(kind, ch, read_index));
                accepted_count++;
            end
            if (!req_valid || req_ready)
            begin
                if (send_wait > 0)
                begin
                    send_wait--;
                    req_valid <= 1'b0;
                end
                else if (char_q.size() > 0)
                begin
                    drive_item = char_q.pop_front();
                    kind <= drive_item.op;
                    ch <= drive_item.chr;
                    read_index <= drive_item.idx;
                    req_valid <= 1'b1;
                    send_wait = draw_gap(send_quiet);
                end
                else
                    req_valid <= 1'b0;
            end
        end
    end

    // ---------------- monitor ----------------

    function automatic void check_field(string name, int want, int got);
        if (want != got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_ready <= 1'b0;
            recv_wait = 0;
        end
        else
        begin
            if (rsp_valid && rsp_ready)
            begin
                if (resolved_q.size() == 0)
                begin
                    $error("response with no item pending: status %0d length %0d char %0d",
                           status, result_length, out_char);
                    mismatches++;
                end
                else
                begin
                    want_rsp = resolved_q.pop_front();
                    check_field("status", want_rsp.status, status);
                    check_field("result_length", want_rsp.len, result_length);
                    check_field("out_char", want_rsp.ochar, out_char);
                end
                recv_wait = draw_gap(recv_quiet);
            end
            if (recv_wait > 0)
            begin
                recv_wait--;
                rsp_ready <= 1'b0;
            end
            else
                rsp_ready <= 1'b1;
        end
    end

    // ---------------- watchdog ----------------

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    // ---------------- sequence ----------------

    initial
    begin
        int pick;
        int directed_count;
        int total_items;

        for (int i = 0; i < STORE_DEPTH; i++)
            path_img[i] = 8'd0;
        load_root();
        cur_phase = PH_IDLE;
        comp_len = 9'd0;
        comp_dots = 1'b0;
        char_count = 9'd0;
        dir_ok = 1'b0;

        // root path, read back inside and past the end
        push_text(KIND_PATH, "/");
        push_item(KIND_PATH, CH_NUL, 8'd0);
        push_item(KIND_READ, CH_NUL, 8'd0);
        push_item(KIND_READ, 8'hFF, 8'd1);
        // empty path
        push_item(KIND_PATH, CH_NUL, 8'd0);
        // relative path under a directory: dot, parent back to root, three dots, high byte
        push_text(KIND_CWD, "/a");
        push_item(KIND_CWD, CH_NUL, 8'd0);
        push_text(KIND_PATH, "./..//.../");
        push_item(KIND_PATH, 8'hFF, 8'd0);
        push_item(KIND_PATH, CH_NUL, 8'd0);
        push_item(KIND_READ, CH_NUL, 8'd254);
        // relative path with no directory
        push_text(KIND_PATH, "z");
        push_item(KIND_PATH, CH_NUL, 8'd0);
        push_item(KIND_NOP, 8'hFF, 8'd0);
        push_item(KIND_READ, CH_NUL, 8'd0);

        directed_count = char_q.size();
        while (char_q.size() < directed_count + RANDOM_ITEMS)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 66)
                push_request(5, 6);
            else if (pick < 76)
                push_noise();
            else if (pick < 86)
                push_misplaced();
            else if (pick < 95)
                push_request(40, 12);
            else if (pick < 97)
                push_reads($urandom_range(4, 10));
            else if (pick < 98)
                push_long_path();
            else
                push_deep_directory();
        end
        total_items = char_q.size();

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        while (accepted_count < total_items)
            @(posedge clk);
        while (resolved_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
